// ----- hdl/achfp_pkg.sv -----
package achfp_pkg;

  // character codes
  localparam logic [7:0] CHR_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CHR_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CHR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHR_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CHR_EIGHT = 8'h38;  // '8'
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHR_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CHR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHR_UF    = 8'h46;  // 'F'

  // field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ID_CHARS = 8;

  // parser states
  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_BANG    = 3'd1,
    ST_ID      = 3'd2,
    ST_COMMA1  = 3'd3,
    ST_LEN     = 3'd4,
    ST_COMMA2  = 3'd5,
    ST_PAYLOAD = 3'd6
  } parse_state_t;

  // one finished frame from the parser core
  typedef struct packed {
    logic               hit;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_len;
    logic [PAY_W-1:0]   frame_payload;
  } frame_res_t;

  // hex digit value, zero for anything that is not a hex digit
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      v = c - CHR_ZERO;
    end else if (c >= CHR_LA && c <= CHR_LF) begin
      v = c - CHR_LA + 8'd10;
    end else if (c >= CHR_UA && c <= CHR_UF) begin
      v = c - CHR_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hdl/achfp_core.sv -----
module achfp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            rx_byte,
  output achfp_pkg::frame_res_t res
);

  achfp_pkg::parse_state_t state_r, state_nxt;
  logic [achfp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [achfp_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [achfp_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [achfp_pkg::PAY_W-1:0] pay_r, pay_nxt;

  logic [3:0]                  nib;
  logic [5:0]                  pay_sh;
  logic [achfp_pkg::PAY_W-1:0] pay_merged;
  logic                        last_char;
  logic                        len_ok;

  // character decode
  assign nib        = achfp_pkg::hex_nibble(rx_byte);
  assign pay_sh     = {count_r[3:1], ~count_r[0], 2'b00};
  assign pay_merged = pay_r | ({{(achfp_pkg::PAY_W-4){1'b0}}, nib} << pay_sh);
  assign last_char  = ({1'b0, count_r} + 5'd1) == {len_r, 1'b0};
  assign len_ok     = (rx_byte >= achfp_pkg::CHR_ONE) && (rx_byte <= achfp_pkg::CHR_EIGHT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      achfp_pkg::ST_HUNT: begin
        state_nxt = (rx_byte == achfp_pkg::CHR_LT) ? achfp_pkg::ST_BANG : achfp_pkg::ST_HUNT;
      end
      achfp_pkg::ST_BANG: begin
        state_nxt = (rx_byte == achfp_pkg::CHR_BANG) ? achfp_pkg::ST_ID : achfp_pkg::ST_HUNT;
      end
      achfp_pkg::ST_ID: begin
        if (count_r == 4'(achfp_pkg::ID_CHARS - 1)) begin
          state_nxt = achfp_pkg::ST_COMMA1;
        end
      end
      achfp_pkg::ST_COMMA1: begin
        state_nxt = (rx_byte == achfp_pkg::CHR_COMMA) ? achfp_pkg::ST_LEN : achfp_pkg::ST_HUNT;
      end
      achfp_pkg::ST_LEN: begin
        state_nxt = len_ok ? achfp_pkg::ST_COMMA2 : achfp_pkg::ST_HUNT;
      end
      achfp_pkg::ST_COMMA2: begin
        state_nxt = (rx_byte == achfp_pkg::CHR_COMMA) ? achfp_pkg::ST_PAYLOAD : achfp_pkg::ST_HUNT;
      end
      achfp_pkg::ST_PAYLOAD: begin
        if (last_char) begin
          state_nxt = achfp_pkg::ST_HUNT;
        end
      end
      default: begin
        state_nxt = achfp_pkg::ST_HUNT;
      end
    endcase
  end

  // accumulators and frame result
  always_comb begin
    count_nxt         = count_r;
    id_nxt            = id_r;
    len_nxt           = len_r;
    pay_nxt           = pay_r;
    res.hit           = 1'b0;
    res.frame_id      = id_r;
    res.frame_len     = len_r;
    res.frame_payload = pay_merged;
    unique case (state_r)
      achfp_pkg::ST_BANG: begin
        if (rx_byte == achfp_pkg::CHR_BANG) begin
          count_nxt = '0;
          id_nxt    = '0;
        end
      end
      achfp_pkg::ST_ID: begin
        id_nxt    = {id_r[achfp_pkg::ID_W-5:0], nib};
        count_nxt = count_r + 4'd1;
      end
      achfp_pkg::ST_LEN: begin
        if (len_ok) begin
          count_nxt = '0;
          len_nxt   = rx_byte[3:0];
          pay_nxt   = '0;
        end
      end
      achfp_pkg::ST_PAYLOAD: begin
        pay_nxt = pay_merged;
        if (last_char) begin
          res.hit   = 1'b1;
          count_nxt = '0;
        end else begin
          count_nxt = count_r + 4'd1;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= achfp_pkg::ST_HUNT;
      count_r <= '0;
      len_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      id_r  <= id_nxt;
      pay_r <= pay_nxt;
    end
  end

  // checks
  a_hit_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> state_r == achfp_pkg::ST_PAYLOAD)
    else $error("frame completed outside payload phase");

  a_id_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == achfp_pkg::ST_ID |-> count_r < 4'(achfp_pkg::ID_CHARS))
    else $error("id character count overran");

  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == achfp_pkg::ST_PAYLOAD |->
      ({1'b0, count_r} < {len_r, 1'b0}) && len_r >= 4'd1 && len_r <= 4'd8)
    else $error("payload count or length out of range");

endmodule

// ----- hdl/ascii_hex_can_frame_parser.sv -----
// a word in the input register steps the parser; a completed frame goes to the output register
// throughput: one word per cycle while the output register is free or being taken
// the input register moves on whenever the output register is empty or being taken
// reset (rst_n low, synchronous) returns the parser to hunting for '<'
// and empties both the input and output registers
module ascii_hex_can_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [achfp_pkg::ID_W-1:0]    out_frame_id,
  output logic [achfp_pkg::LEN_W-1:0]   out_frame_len,
  output logic [achfp_pkg::PAY_W-1:0]   out_frame_payload
);

  logic                         in_valid_r;
  logic [7:0]                   in_byte_r;
  logic                         out_valid_r;
  logic [achfp_pkg::ID_W-1:0]   out_id_r;
  logic [achfp_pkg::LEN_W-1:0]  out_len_r;
  logic [achfp_pkg::PAY_W-1:0]  out_pay_r;
  logic                         adv;
  logic                         step_en;
  achfp_pkg::frame_res_t        res;

  // pipeline advance
  assign adv      = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // parser
  achfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step_en && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.hit) begin
      out_id_r  <= res.frame_id;
      out_len_r <= res.frame_len;
      out_pay_r <= res.frame_payload;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_id      = out_id_r;
  assign out_frame_len     = out_len_r;
  assign out_frame_payload = out_pay_r;

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !step_en)
    else $error("held frame would be overwritten");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_len_r >= 4'd1 && out_len_r <= 4'd8)
    else $error("frame length out of range");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with nothing pending");

endmodule
